### rtl/njs_pkg.sv
// ----------------------------------------------------------------------------
// njs_pkg
// Shared types and constants of the nearest-job scheduler with recompile quota.
// ----------------------------------------------------------------------------
package njs_pkg;

   localparam int TAG_W      = 16;
   localparam int CHUNK_W    = 22;
   localparam int SEC_W      = 5;
   localparam int CAM_W      = 30;
   localparam int QUOTA_W    = 4;
   localparam int YW_W       = 16;
   localparam int DROP_W     = 7;
   localparam int DIST_W     = 64;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [QUOTA_W-1:0]    QUOTA_RESET   = 4'd2;
   localparam logic [YW_W-1:0]       YW_RESET      = 16'd655;
   localparam logic [DROP_W-1:0]     DROP_MAX      = 7'd127;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_QUOTA = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_Y_WEIGHT  = 2'd1;

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_POLL    = 2'd1,
      ACT_CANCEL  = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_GRANTED = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic                       cancelled;
      logic                       recompile;
      logic [SEC_W-1:0]           section;
      logic signed [CHUNK_W-1:0]  chunk_z;
      logic signed [CHUNK_W-1:0]  chunk_x;
      logic [TAG_W-1:0]           tag;
   } job_type;

   typedef enum logic [1:0] {RD_IDX, RD_LAST, RD_CHOSEN} rd_sel_type;
   typedef enum logic [1:0] {WA_COUNT, WA_IDX, WA_CHOSEN} wa_sel_type;
   typedef enum logic [1:0] {WD_REQ, WD_MARK, WD_RDATA} wd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_CAN_RD, S_CAN_CHK, S_CMP_RD, S_CMP_CHK, S_CMP_MOVE,
      S_SCAN, S_DRAIN, S_DECIDE, S_GRANT_RD, S_GRANT_CAP, S_GRANT_MOVE, S_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wa_sel_type wa_sel;
      wd_sel_type wd_sel;
      logic       idx_inc;
      logic       idx_clr;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       drop_inc;
      logic       quota_refill;
      logic       decide;
      logic       scan_issue;
      logic       best_clr;
      logic       cap_grant;
      logic       set_status;
      status_type status;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       full;
      logic       cnt_zero;
      logic       idx_at_end;
      logic       idx_is_last;
      logic       rd_cancelled;
      logic       tag_match;
      logic       pipe_busy;
      logic       chosen_is_last;
      logic       rsp_free;
   } stat_type;

endpackage

### rtl/njs_ram.sv
// ----------------------------------------------------------------------------
// njs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module njs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/njs_dist.sv
// ----------------------------------------------------------------------------
// njs_dist
// Four-stage pipeline for the Y-weighted squared distance of a job to the camera.
// ----------------------------------------------------------------------------
module njs_dist #(
   parameter int IDX_W = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [IDX_W-1:0]                  in_idx,
   input  njs_pkg::job_type                  job,
   input  logic signed [njs_pkg::CAM_W-1:0]  cam_x,
   input  logic signed [njs_pkg::CAM_W-1:0]  cam_y,
   input  logic signed [njs_pkg::CAM_W-1:0]  cam_z,
   input  logic [njs_pkg::YW_W-1:0]          y_weight,
   output logic                              out_valid,
   output logic [IDX_W-1:0]                  out_idx,
   output logic                              out_recompile,
   output logic [njs_pkg::DIST_W-1:0]        out_dist,
   output logic                              busy
);
   import njs_pkg::*;

   logic [29:0] px, pz;
   logic [13:0] py;
   logic [30:0] dx, dy, dz;
   logic [30:0] ax, ay, az;

   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0] i1_ff, i2_ff, i3_ff, i4_ff;
   logic             r1_ff, r2_ff, r3_ff, r4_ff;
   logic [30:0]      ax_ff, ay_ff, az_ff;
   logic [61:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [61:0]      phi_ff;
   logic [31:0]      plo_ff;
   logic [62:0]      sxz_ff;
   logic [DIST_W-1:0] dist_ff;

   // section centre in sixteenths of a block
   assign px = {job.chunk_x, 8'h80};
   assign pz = {job.chunk_z, 8'h80};
   assign py = {1'b0, job.section, 8'h00} - 14'd896;

   assign dx = {px[29], px} - {cam_x[29], cam_x};
   assign dz = {pz[29], pz} - {cam_z[29], cam_z};
   assign dy = {{17{py[13]}}, py} - {cam_y[29], cam_y};

   assign ax = dx[30] ? (31'd0 - dx) : dx;
   assign ay = dy[30] ? (31'd0 - dy) : dy;
   assign az = dz[30] ? (31'd0 - dz) : dz;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1 absolute differences, stage 2 squares
   // stage 3 weight product and horizontal sum, stage 4 total
   always_ff @(posedge clock) begin
      i1_ff   <= in_idx;
      r1_ff   <= job.recompile;
      ax_ff   <= ax;
      ay_ff   <= ay;
      az_ff   <= az;
      i2_ff   <= i1_ff;
      r2_ff   <= r1_ff;
      sqx_ff  <= ax_ff * ax_ff;
      sqy_ff  <= ay_ff * ay_ff;
      sqz_ff  <= az_ff * az_ff;
      i3_ff   <= i2_ff;
      r3_ff   <= r2_ff;
      phi_ff  <= sqy_ff[61:16] * y_weight;
      plo_ff  <= sqy_ff[15:0] * y_weight;
      sxz_ff  <= {1'b0, sqx_ff} + {1'b0, sqz_ff};
      i4_ff   <= i3_ff;
      r4_ff   <= r3_ff;
      dist_ff <= {1'b0, sxz_ff} + {2'b00, phi_ff} + {48'd0, plo_ff[31:16]};
   end

   assign out_valid     = v4_ff;
   assign out_idx       = i4_ff;
   assign out_recompile = r4_ff;
   assign out_dist      = dist_ff;
   assign busy          = v1_ff | v2_ff | v3_ff;

endmodule

### rtl/njs_datapath.sv
// ----------------------------------------------------------------------------
// njs_datapath
// Job table, counters, quota, nearest-job trackers and the result register.
// ----------------------------------------------------------------------------
module njs_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  njs_pkg::cmd_type                    cmd,
   output njs_pkg::stat_type                   stat,
   input  njs_pkg::action_type                 req_action,
   input  njs_pkg::job_type                    req_job,
   input  logic signed [njs_pkg::CAM_W-1:0]    req_cam_x,
   input  logic signed [njs_pkg::CAM_W-1:0]    req_cam_y,
   input  logic signed [njs_pkg::CAM_W-1:0]    req_cam_z,
   input  logic                                csr_wen,
   input  logic [njs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [njs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output njs_pkg::status_type                 rsp_status,
   output njs_pkg::job_type                    rsp_job,
   output logic [njs_pkg::DROP_W-1:0]          rsp_drop
);
   import njs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // request and configuration registers
   action_type             act_ff;
   job_type                req_job_ff;
   logic signed [CAM_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [QUOTA_W-1:0]     max_quota_ff;
   logic [YW_W-1:0]        y_weight_ff;

   // control registers
   logic [QUOTA_W-1:0] quota_ff, quota_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic [IDX_W-1:0]   chosen_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               scan_v_ff;
   logic [IDX_W-1:0]   scan_idx_ff;

   // trackers
   logic               has_i_ff, has_r_ff;
   logic [DIST_W-1:0]  di_ff, dr_ff;
   logic [IDX_W-1:0]   bi_ff, br_ff;

   // result staging and output
   status_type res_status_ff, rsp_status_ff;
   job_type    res_job_ff, rsp_job_ff;
   logic [DROP_W-1:0] rsp_drop_ff;

   logic [CNT_W-1:0]  cnt_m1;
   logic [IDX_W-1:0]  last_a, idx_a, raddr, waddr;
   job_type           rdata, wdata, grant_job;
   logic [$bits(job_type)-1:0] rdata_raw;
   logic              pick_r;
   logic              d_valid, d_rc, d_busy;
   logic [IDX_W-1:0]  d_idx;
   logic [DIST_W-1:0] d_dist;

   assign cnt_m1 = count_ff - 1'b1;
   assign last_a = cnt_m1[IDX_W-1:0];
   assign idx_a  = idx_ff[IDX_W-1:0];
   assign rdata  = job_type'(rdata_raw);

   // address and write data selection
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:    raddr = idx_a;
         RD_LAST:   raddr = last_a;
         RD_CHOSEN: raddr = chosen_ff;
         default:   raddr = idx_a;
      endcase
      case (cmd.wa_sel)
         WA_COUNT:  waddr = count_ff[IDX_W-1:0];
         WA_IDX:    waddr = idx_a;
         WA_CHOSEN: waddr = chosen_ff;
         default:   waddr = idx_a;
      endcase
      wdata = rdata;
      case (cmd.wd_sel)
         WD_REQ:   wdata = req_job_ff;
         WD_MARK:  wdata.cancelled = 1'b1;
         WD_RDATA: wdata = rdata;
         default:  wdata = rdata;
      endcase
   end

   njs_ram #(
      .WIDTH ($bits(job_type)),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (rdata_raw)
   );

   njs_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (scan_v_ff),
      .in_idx        (scan_idx_ff),
      .job           (rdata),
      .cam_x         (cam_x_ff),
      .cam_y         (cam_y_ff),
      .cam_z         (cam_z_ff),
      .y_weight      (y_weight_ff),
      .out_valid     (d_valid),
      .out_idx       (d_idx),
      .out_recompile (d_rc),
      .out_dist      (d_dist),
      .busy          (d_busy)
   );

   // grant choice: recompile only if strictly nearer with quota left, or alone
   assign pick_r = has_r_ff &&
                   !(has_i_ff && ((quota_ff == '0) || !(dr_ff < di_ff)));

   // next values of control state
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = cnt_m1;
      end

      idx_in = idx_ff;
      if (cmd.load || cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      drop_in = drop_ff;
      if (cmd.load) begin
         drop_in = '0;
      end else if (cmd.drop_inc && (drop_ff != DROP_MAX)) begin
         drop_in = drop_ff + 1'b1;
      end

      quota_in = quota_ff;
      if (cmd.quota_refill) begin
         quota_in = max_quota_ff;
      end else if (cmd.decide) begin
         if (!pick_r) begin
            quota_in = max_quota_ff;
         end else if (quota_ff != '0) begin
            quota_in = quota_ff - 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= ACT_ENQUEUE;
         count_ff     <= '0;
         idx_ff       <= '0;
         drop_ff      <= '0;
         quota_ff     <= QUOTA_RESET;
         max_quota_ff <= QUOTA_RESET;
         y_weight_ff  <= YW_RESET;
         rsp_valid_ff <= 1'b0;
         scan_v_ff    <= 1'b0;
         has_i_ff     <= 1'b0;
         has_r_ff     <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         drop_ff      <= drop_in;
         quota_ff     <= quota_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_v_ff    <= cmd.scan_issue;
         if (cmd.load) begin
            act_ff <= req_action;
         end
         // configuration writes
         if (csr_wen && (csr_addr == CSR_MAX_QUOTA)) begin
            max_quota_ff <= csr_wdata[QUOTA_W-1:0];
         end
         if (csr_wen && (csr_addr == CSR_Y_WEIGHT)) begin
            y_weight_ff <= csr_wdata[YW_W-1:0];
         end
         // nearest-job trackers, lower slot wins ties
         if (cmd.best_clr) begin
            has_i_ff <= 1'b0;
            has_r_ff <= 1'b0;
         end else if (d_valid) begin
            if (d_rc && (!has_r_ff || (d_dist < dr_ff))) begin
               has_r_ff <= 1'b1;
            end
            if (!d_rc && (!has_i_ff || (d_dist < di_ff))) begin
               has_i_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_job_ff    <= req_job;
         cam_x_ff      <= req_cam_x;
         cam_y_ff      <= req_cam_y;
         cam_z_ff      <= req_cam_z;
         res_status_ff <= ST_DONE;
         res_job_ff    <= '0;
      end else if (cmd.cap_grant) begin
         res_status_ff <= ST_GRANTED;
         res_job_ff    <= grant_job;
      end else if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      scan_idx_ff <= idx_a;
      if (d_valid && d_rc && (!has_r_ff || (d_dist < dr_ff))) begin
         dr_ff <= d_dist;
         br_ff <= d_idx;
      end
      if (d_valid && !d_rc && (!has_i_ff || (d_dist < di_ff))) begin
         di_ff <= d_dist;
         bi_ff <= d_idx;
      end
      if (cmd.decide) begin
         chosen_ff <= pick_r ? br_ff : bi_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_job_ff    <= res_job_ff;
         rsp_drop_ff   <= drop_ff;
      end
   end

   always_comb begin
      grant_job           = rdata;
      grant_job.cancelled = 1'b0;
   end

   // status back to the controller
   assign stat.action         = act_ff;
   assign stat.full           = (count_ff == CNT_W'(DEPTH));
   assign stat.cnt_zero       = (count_ff == '0);
   assign stat.idx_at_end     = (idx_ff == count_ff);
   assign stat.idx_is_last    = (idx_ff == cnt_m1);
   assign stat.rd_cancelled   = rdata.cancelled;
   assign stat.tag_match      = (rdata.tag == req_job_ff.tag);
   assign stat.pipe_busy      = scan_v_ff | d_busy;
   assign stat.chosen_is_last = (chosen_ff == last_a);
   assign stat.rsp_free       = !rsp_valid_ff || rsp_tready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_job    = rsp_job_ff;
   assign rsp_drop   = rsp_drop_ff;

   // table occupancy stays within depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");
   // no removal from an empty table
   assert property (@(posedge clock) disable iff (reset) cmd.cnt_dec |-> (count_ff != '0))
      else $error("removal with empty table");
   // no append into a full table
   assert property (@(posedge clock) disable iff (reset) cmd.cnt_inc |-> !stat.full)
      else $error("append into full table");
   // drops are only counted by a poll
   assert property (@(posedge clock) disable iff (reset)
      (drop_ff != '0) |-> (act_ff == ACT_POLL))
      else $error("drop count outside poll");

endmodule

### rtl/njs_ctrl.sv
// ----------------------------------------------------------------------------
// njs_ctrl
// Sequencer for enqueue, cancel sweep, compaction, distance scan and grant.
// ----------------------------------------------------------------------------
module njs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  njs_pkg::stat_type stat,
   output njs_pkg::cmd_type  cmd
);
   import njs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_IDX;
      cmd.wa_sel = WA_IDX;
      cmd.wd_sel = WD_RDATA;
      cmd.status = ST_DONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         // decode the held action
         S_DISPATCH: begin
            case (stat.action)
               ACT_ENQUEUE: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wa_sel  = WA_COUNT;
                     cmd.wd_sel  = WD_REQ;
                     cmd.cnt_inc = 1'b1;
                  end
                  state_in = S_FINISH;
               end
               ACT_POLL:   state_in = S_CMP_RD;
               ACT_CANCEL: state_in = S_CAN_RD;
               ACT_CLEAR: begin
                  cmd.cnt_clr      = 1'b1;
                  cmd.quota_refill = 1'b1;
                  state_in         = S_FINISH;
               end
               default: state_in = S_FINISH;
            endcase
         end
         // cancel sweep, read then mark
         S_CAN_RD: begin
            if (stat.idx_at_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CAN_CHK;
            end
         end
         S_CAN_CHK: begin
            if (stat.tag_match) begin
               cmd.wr_en  = 1'b1;
               cmd.wd_sel = WD_MARK;
            end
            cmd.idx_inc = 1'b1;
            state_in    = S_CAN_RD;
         end
         // compaction by swap-and-pop
         S_CMP_RD: begin
            if (stat.idx_at_end) begin
               if (stat.cnt_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_EMPTY;
                  state_in       = S_FINISH;
               end else begin
                  cmd.idx_clr  = 1'b1;
                  cmd.best_clr = 1'b1;
                  state_in     = S_SCAN;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CMP_CHK;
            end
         end
         S_CMP_CHK: begin
            if (!stat.rd_cancelled) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_CMP_RD;
            end else begin
               cmd.drop_inc = 1'b1;
               if (stat.idx_is_last) begin
                  cmd.cnt_dec = 1'b1;
                  state_in    = S_CMP_RD;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_LAST;
                  state_in   = S_CMP_MOVE;
               end
            end
         end
         // moved entry is checked again from the held read data
         S_CMP_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.cnt_dec = 1'b1;
            state_in    = S_CMP_CHK;
         end
         // one read per cycle into the distance pipeline
         S_SCAN: begin
            cmd.rd_en      = 1'b1;
            cmd.scan_issue = 1'b1;
            if (stat.idx_is_last) begin
               state_in = S_DRAIN;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_GRANT_RD;
         end
         S_GRANT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CHOSEN;
            state_in   = S_GRANT_CAP;
         end
         S_GRANT_CAP: begin
            cmd.cap_grant = 1'b1;
            if (stat.chosen_is_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = S_GRANT_MOVE;
            end
         end
         S_GRANT_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_CHOSEN;
            cmd.cnt_dec = 1'b1;
            state_in    = S_FINISH;
         end
         // hand the result to the output register once it is free
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### rtl/nearest_job_scheduler_with_quota.sv
// ----------------------------------------------------------------------------
// nearest_job_scheduler_with_quota
// Job table with cancel, compaction and nearest-job grant under a recompile quota.
// ----------------------------------------------------------------------------
// channel  direction  beat contents
// req      in         tuser: action; tdata: tag, chunk x/z, section, recompile, camera
// rsp      out        tuser: status; tdata: granted job fields, dropped count
// csr      in         write enable, register index, write data
//
// enqueue and clear need no table sweep; cancel reads each entry, then marks it on a tag match
// poll: compaction reads every entry, kept or dropped, then the distance scan reads
// each entry left, before the grant; all paced by the single table read port
// reset clears the count and sets the quota to its reset value; table contents need no clearing
// a finished beat waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module nearest_job_scheduler_with_quota #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tag, chunk_x, chunk_z, section_y, is_recompile, cam_x, cam_y, cam_z
   input  logic [njs_pkg::REQ_DATA_W-1:0]       req_tdata,
   // action
   input  logic [njs_pkg::ACT_W-1:0]            req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_tag, out_chunk_x, out_chunk_z, out_section, out_recompile, dropped_count
   output logic [njs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status
   output logic [njs_pkg::STAT_W-1:0]           rsp_tuser,
   input  logic                                 csr_wen,
   input  logic [njs_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [njs_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import njs_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   job_type    req_job, rsp_job;
   status_type rsp_status;
   logic [DROP_W-1:0] rsp_drop;

   // unpack the request beat
   assign req_job.tag       = req_tdata[15:0];
   assign req_job.chunk_x   = req_tdata[37:16];
   assign req_job.chunk_z   = req_tdata[59:38];
   assign req_job.section   = req_tdata[64:60];
   assign req_job.recompile = req_tdata[65];
   assign req_job.cancelled = 1'b0;

   njs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   njs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (action_type'(req_tuser)),
      .req_job    (req_job),
      .req_cam_x  (req_tdata[95:66]),
      .req_cam_y  (req_tdata[125:96]),
      .req_cam_z  (req_tdata[155:126]),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_job    (rsp_job),
      .rsp_drop   (rsp_drop)
   );

   // pack the result beat
   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {7'd0, rsp_drop, rsp_job.recompile, rsp_job.section,
                       rsp_job.chunk_z, rsp_job.chunk_x, rsp_job.tag};

endmodule

### tb/tb_nearest_job_scheduler_with_quota.sv
// ----------------------------------------------------------------------------
// tb_nearest_job_scheduler_with_quota
// Self-checking bench: a directed table of stimulus, then random phases under
// several register settings. Every result beat is checked against an
// in-bench model of the job table, the quota and the distance arbitration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_job_scheduler_with_quota;
   import njs_pkg::*;

   localparam int TBL_DEPTH = 64;
   localparam int N_RANDOM  = 1130;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      action_type             act;
      logic [TAG_W-1:0]       tag;
      logic signed [CHUNK_W-1:0] cx;
      logic signed [CHUNK_W-1:0] cz;
      logic [SEC_W-1:0]       sec;
      logic                   rc;
      logic signed [CAM_W-1:0] camx;
      logic signed [CAM_W-1:0] camy;
      logic signed [CAM_W-1:0] camz;
   } sched_req_type;

   typedef struct {
      status_type             st;
      logic [TAG_W-1:0]       tag;
      logic [CHUNK_W-1:0]     cx;
      logic [CHUNK_W-1:0]     cz;
      logic [SEC_W-1:0]       sec;
      logic                   rc;
      logic [DROP_W-1:0]      dropped;
   } sched_rsp_type;

   typedef struct {
      sched_req_type r;
      logic          typed;
      status_type    st;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   nearest_job_scheduler_with_quota u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state of the job table
   logic [TAG_W-1:0]   m_tag [TBL_DEPTH];
   logic [CHUNK_W-1:0] m_cx  [TBL_DEPTH];
   logic [CHUNK_W-1:0] m_cz  [TBL_DEPTH];
   logic [SEC_W-1:0]   m_sec [TBL_DEPTH];
   logic               m_rc  [TBL_DEPTH];
   logic               m_cnl [TBL_DEPTH];
   int                 m_count;
   logic [QUOTA_W-1:0] m_quota;
   logic [QUOTA_W-1:0] m_max_quota;
   logic [YW_W-1:0]    m_y_weight;

   sched_rsp_type pending_rsp[$];
   int mismatches = 0;
   logic quiet = 1'b0;

   function automatic void drop_slot(int i);
      int last;
      last = m_count - 1;
      m_tag[i] = m_tag[last]; m_cx[i] = m_cx[last]; m_cz[i] = m_cz[last];
      m_sec[i] = m_sec[last]; m_rc[i] = m_rc[last]; m_cnl[i] = m_cnl[last];
      m_count = last;
   endfunction

   // squared distance from the camera to the section centre, vertical part weighted
   function automatic longint unsigned centre_distance(int i, sched_req_type r);
      longint px, py, pz, dx, dy, dz;
      longint unsigned yy, w;
      px = longint'($signed(m_cx[i])) * 256 + 128;
      pz = longint'($signed(m_cz[i])) * 256 + 128;
      py = longint'(m_sec[i]) * 256 - 896;
      dx = px - longint'(r.camx); dy = py - longint'(r.camy); dz = pz - longint'(r.camz);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      yy = dy * dy;
      w = 64'(m_y_weight);
      return dx * dx + dz * dz + (yy >> 16) * w + (((yy & 64'hFFFF) * w) >> 16);
   endfunction

   function automatic sched_rsp_type predict_grant(sched_req_type r);
      sched_rsp_type o;
      int i, dropped, bi, br;
      bit has_i, has_r;
      longint unsigned d, di, dr;
      o = '{ST_DONE, '0, '0, '0, '0, 1'b0, '0};
      dropped = 0; bi = 0; br = 0; has_i = 0; has_r = 0; di = 0; dr = 0;
      case (r.act)
         ACT_ENQUEUE: begin
            if (m_count >= TBL_DEPTH) o.st = ST_FULL;
            else begin
               m_tag[m_count] = r.tag; m_cx[m_count] = r.cx; m_cz[m_count] = r.cz;
               m_sec[m_count] = r.sec; m_rc[m_count] = r.rc; m_cnl[m_count] = 1'b0;
               m_count++;
            end
         end
         ACT_CANCEL: begin
            for (i = 0; i < m_count; i++) if (m_tag[i] == r.tag) m_cnl[i] = 1'b1;
         end
         ACT_CLEAR: begin
            m_count = 0;
            m_quota = m_max_quota;
         end
         default: begin
            // compaction of cancelled entries
            i = 0;
            while (i < m_count) begin
               if (m_cnl[i]) begin drop_slot(i); dropped++; end
               else i++;
            end
            o.dropped = (dropped > 127) ? 7'd127 : DROP_W'(dropped);
            if (m_count == 0) o.st = ST_EMPTY;
            else begin
               for (i = 0; i < m_count; i++) begin
                  d = centre_distance(i, r);
                  if (m_rc[i]) begin
                     if (!has_r || d < dr) begin has_r = 1; dr = d; br = i; end
                  end else if (!has_i || d < di) begin
                     has_i = 1; di = d; bi = i;
                  end
               end
               if (!has_r || (has_i && (m_quota == 0 || !(dr < di)))) begin
                  m_quota = m_max_quota;
                  i = bi;
               end else begin
                  if (m_quota != 0) m_quota--;
                  i = br;
               end
               o.st = ST_GRANTED;
               o.tag = m_tag[i]; o.cx = m_cx[i]; o.cz = m_cz[i];
               o.sec = m_sec[i]; o.rc = m_rc[i];
               drop_slot(i);
            end
         end
      endcase
      return o;
   endfunction

   function automatic sched_req_type mk(action_type a, int tag, int cx, int cz, int sec,
                                        int rc, int camx, int camy, int camz);
      sched_req_type r;
      r.act = a; r.tag = TAG_W'(tag); r.cx = CHUNK_W'(cx); r.cz = CHUNK_W'(cz);
      r.sec = SEC_W'(sec); r.rc = 1'(rc);
      r.camx = CAM_W'(camx); r.camy = CAM_W'(camy); r.camz = CAM_W'(camz);
      return r;
   endfunction

   // random beat: small neighbourhood mostly, so ties and cancels hit; full range sometimes
   function automatic sched_req_type random_req(int enq_pct);
      sched_req_type r;
      int p;
      p = $urandom_range(99);
      if (p < enq_pct) r.act = ACT_ENQUEUE;
      else if (p < enq_pct + (100 - enq_pct) * 70 / 100) r.act = ACT_POLL;
      else if (p < 98) r.act = ACT_CANCEL;
      else r.act = ACT_CLEAR;
      r.tag = ($urandom_range(9) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(7));
      r.sec = SEC_W'($urandom_range(31));
      r.rc = 1'($urandom_range(1));
      if ($urandom_range(9) == 0) begin
         r.cx = CHUNK_W'($urandom); r.cz = CHUNK_W'($urandom);
         r.camx = CAM_W'($urandom); r.camy = CAM_W'($urandom); r.camz = CAM_W'($urandom);
      end else begin
         r.cx = CHUNK_W'($signed($urandom_range(16)) - 8);
         r.cz = CHUNK_W'($signed($urandom_range(16)) - 8);
         r.camx = CAM_W'($signed($urandom_range(4096)) - 2048);
         r.camy = CAM_W'($signed($urandom_range(8192)) - 1024);
         r.camz = CAM_W'($signed($urandom_range(4096)) - 2048);
      end
      return r;
   endfunction

   task automatic send_beat(stim_row_type s);
      sched_rsp_type e;
      if (!quiet && $urandom_range(99) < 17) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= s.r.act;
      req_tdata <= {4'b0, s.r.camz, s.r.camy, s.r.camx, s.r.rc, s.r.sec,
                    s.r.cz, s.r.cx, s.r.tag};
      do @(posedge clock); while (!req_tready);
      e = predict_grant(s.r);
      if (s.typed) e = '{s.st, '0, '0, '0, '0, 1'b0, '0};
      pending_rsp = {pending_rsp, e};
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] a, int v);
      @(negedge clock);
      csr_wen <= 1'b1; csr_addr <= a; csr_wdata <= CSR_DATA_W'(v);
      @(posedge clock);
      if (a == CSR_MAX_QUOTA) m_max_quota = QUOTA_W'(v);
      else if (a == CSR_Y_WEIGHT) m_y_weight = YW_W'(v);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic settle;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // result side: random back-pressure, driven at the falling edge
   always @(negedge clock) begin
      rsp_tready <= !reset && (quiet || $urandom_range(99) >= 17);
   end

   // result checking against the oldest expectation
   always @(posedge clock) begin
      sched_rsp_type e, a;
      if (rsp_tvalid && rsp_tready) begin
         a.st = status_type'(rsp_tuser);
         {a.dropped, a.rc, a.sec, a.cz, a.cx, a.tag} = rsp_tdata[72:0];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat st=%0d", a.st);
         end else begin
            e = pending_rsp.pop_front();
            if (a.st !== e.st || a.tag !== e.tag || a.cx !== e.cx || a.cz !== e.cz ||
                a.sec !== e.sec || a.rc !== e.rc || a.dropped !== e.dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d tag=%h x=%h z=%h sec=%0d rc=%b drop=%0d, %s",
                           e.st, e.tag, e.cx, e.cz, e.sec, e.rc, e.dropped,
                           $sformatf("got st=%0d tag=%h x=%h z=%h sec=%0d rc=%b drop=%0d",
                                     a.st, a.tag, a.cx, a.cz, a.sec, a.rc, a.dropped));
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      stim_row_type dir_rows[$];
      stim_row_type s;
      int ph, n;
      m_count = 0;
      m_quota = QUOTA_RESET;
      m_max_quota = QUOTA_RESET;
      m_y_weight = YW_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: extremes, every action, ties, cancel and drop
      dir_rows = '{
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_EMPTY},
         '{mk(ACT_CANCEL, 16'h1234, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_ENQUEUE, 16'hFFFF, -2097152, 2097151, 0, 0, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_ENQUEUE, 0, 2097151, -2097152, 31, 1, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_ENQUEUE, 5, 0, 0, 23, 1, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_ENQUEUE, 5, -1, -1, 4, 0, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, -536870912, -536870912, -536870912), 1'b0, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 536870911, 536870911, 536870911), 1'b0, ST_DONE},
         '{mk(ACT_CANCEL, 5, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ST_DONE},
         '{mk(ACT_ENQUEUE, 9, 0, 0, 4, 1, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_ENQUEUE, 10, 0, 0, 4, 1, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_ENQUEUE, 11, 0, 0, 4, 0, 0, 0, 0), 1'b1, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 128, 256, 128), 1'b0, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 128, 256, 128), 1'b0, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 128, 256, 128), 1'b0, ST_DONE},
         '{mk(ACT_POLL, 0, 0, 0, 0, 0, 128, 256, 128), 1'b0, ST_DONE},
         '{mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_DONE}
      };
      foreach (dir_rows[i]) send_beat(dir_rows[i]);
      settle();

      // random phases, each under its own register setting
      n = 0;
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_MAX_QUOTA, 0); write_reg(CSR_Y_WEIGHT, 0); end
            1: begin write_reg(CSR_MAX_QUOTA, 15); write_reg(CSR_Y_WEIGHT, 16'hFFFF); end
            2: begin write_reg(CSR_UNUSED, 16'hFFFF); write_reg(CSR_MAX_QUOTA, 1); end
            3: begin write_reg(CSR_MAX_QUOTA, 2); write_reg(CSR_Y_WEIGHT, 655); end
            default: begin
               write_reg(CSR_MAX_QUOTA, $urandom_range(15));
               write_reg(CSR_Y_WEIGHT, $urandom_range(16'hFFFF));
            end
         endcase
         for (int k = 0; k < N_RANDOM / 6; k++) begin
            quiet = (n >= 400 && n < 550);
            s.typed = 1'b0;
            s.st = ST_DONE;
            // one phase leans on enqueue so the table fills up
            s.r = random_req(ph == 2 ? 80 : 45);
            send_beat(s);
            n++;
         end
         settle();
      end
      quiet = 1'b0;

      repeat (20) @(negedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/njs_pkg.sv
rtl/njs_ram.sv
rtl/njs_dist.sv
rtl/njs_datapath.sv
rtl/njs_ctrl.sv
rtl/nearest_job_scheduler_with_quota.sv
tb/tb_nearest_job_scheduler_with_quota.sv
